[rtl/core/lfu_pkg.sv]
package lfu_pkg;

	localparam int WORD_W  = 32;
	localparam int CLOCK_W = 48;
	localparam int CFG_W   = 5;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CLOCK_W-1:0]       stamp_t;
	typedef logic [CFG_W-1:0]         cfg_t;

	// operation codes
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	localparam word_t MISS_VALUE = -32'sd1;
	localparam cfg_t  CAP_RESET  = 5'd16;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_LOAD   = 5'b01000,
		ST_RESP   = 5'b10000
	} state_t;

	typedef struct packed {
		logic  hit;
		word_t read_value;
		logic  evicted;
		word_t evicted_key;
	} result_t;

endpackage

[rtl/core/lfu_cache_policy_unit.sv]
// Steps: accept, scan of every entry, decide, data load (get hit only), respond. One item at a
// time: input is stalled until the response is loaded; the scan reads one
//   entry per cycle through the single read port of the entry table.
// Reset: valid bits, fill count and use clock cleared, capacity set to 16; entry
//   contents are not cleared and no clearing pass is run.
module lfu_cache_policy_unit #(
	parameter int ENTRIES    = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// config write
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  lfu_pkg::cfg_t      cfg_data,
	// request
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  lfu_pkg::word_t     key,
	input  lfu_pkg::word_t     value,
	// response
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output lfu_pkg::word_t     read_value,
	output logic               evicted,
	output lfu_pkg::word_t     evicted_key
);
	import lfu_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	localparam logic [CNT_W-1:0] LAST_SCAN = CNT_W'(ENTRIES);
	localparam count_t           COUNT_MAX = '1;
	localparam count_t           COUNT_ONE = COUNT_BITS'(1);

	// entry table: key/count/stamp share one address, data is its own memory
	word_t  key_mem   [ENTRIES];
	count_t cnt_mem   [ENTRIES];
	stamp_t stamp_mem [ENTRIES];
	word_t  data_mem  [ENTRIES];

	state_t            state_q;
	cfg_t              capacity_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]  filled_q;
	stamp_t            use_clock_q;
	logic [CNT_W-1:0]  scan_idx_q;

	// latched request
	logic  cmd_q;
	word_t key_q;
	word_t value_q;

	// scan read pipeline
	logic   chk_s1;
	idx_t   chk_idx_s1;
	logic   chk_valid_s1;
	word_t  rd_key_s1;
	count_t rd_cnt_s1;
	stamp_t rd_stamp_s1;

	// scan findings
	logic   match_found_q;
	idx_t   match_idx_q;
	count_t match_cnt_q;
	logic   vic_found_q;
	idx_t   vic_idx_q;
	count_t vic_cnt_q;
	stamp_t vic_stamp_q;
	word_t  vic_key_q;
	logic   free_found_q;
	idx_t   free_idx_q;

	word_t   data_rd_q;
	result_t res_q;

	logic   in_acc;
	logic   out_free;
	logic   scan_issue;
	idx_t   scan_addr;
	logic   is_better;

	// decide-step actions
	logic   meta_we;
	idx_t   meta_addr;
	count_t meta_cnt;
	logic   data_we;
	logic   data_re;
	logic   full;
	logic   do_evict;
	logic   do_ins;
	idx_t   ins_idx;
	count_t cnt_inc;
	logic [ENTRIES-1:0] valid_d;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;

	assign scan_issue = (state_q == ST_SCAN) && (scan_idx_q != LAST_SCAN);
	assign scan_addr  = scan_idx_q[IDX_W-1:0];

	// lowest count first, older stamp on equal count; first index keeps ties
	assign is_better = !vic_found_q ||
		({rd_cnt_s1, rd_stamp_s1} < {vic_cnt_q, vic_stamp_q});

	// table counts as full once filled reaches min(capacity, ENTRIES)
	assign full = (CMP_W'(filled_q) >= CMP_W'(capacity_q)) || (filled_q == LAST_SCAN);
	assign cnt_inc = (match_cnt_q == COUNT_MAX) ? match_cnt_q : match_cnt_q + COUNT_ONE;

	always_comb begin
		meta_we   = 1'b0;
		meta_addr = match_idx_q;
		meta_cnt  = cnt_inc;
		data_we   = 1'b0;
		data_re   = 1'b0;
		do_evict  = 1'b0;
		do_ins    = 1'b0;
		ins_idx   = vic_idx_q;
		if (state_q == ST_DECIDE) begin
			if (cmd_q == CMD_GET) begin
				if (match_found_q) begin
					meta_we = 1'b1;
					data_re = 1'b1;
				end
			end else if (capacity_q != '0) begin
				if (match_found_q) begin
					meta_we = 1'b1;
					data_we = 1'b1;
				end else begin
					do_evict = full && vic_found_q;
					// freed victim or lower empty slot, whichever comes first
					if (free_found_q && (!do_evict || (free_idx_q < vic_idx_q))) begin
						ins_idx = free_idx_q;
					end
					do_ins    = free_found_q || do_evict;
					meta_we   = do_ins;
					data_we   = do_ins;
					meta_addr = ins_idx;
					meta_cnt  = COUNT_ONE;
				end
			end
		end
		// victim cleared first, new entry may land in the same slot
		valid_d = valid_q;
		if (do_evict) begin
			valid_d[vic_idx_q] = 1'b0;
		end
		if (do_ins) begin
			valid_d[ins_idx] = 1'b1;
		end
	end

	// entry table ports
	always_ff @(posedge clk) begin
		if (scan_issue) begin
			rd_key_s1   <= key_mem[scan_addr];
			rd_cnt_s1   <= cnt_mem[scan_addr];
			rd_stamp_s1 <= stamp_mem[scan_addr];
		end
		if (meta_we) begin
			key_mem[meta_addr]   <= key_q;
			cnt_mem[meta_addr]   <= meta_cnt;
			stamp_mem[meta_addr] <= use_clock_q;
		end
	end

	always_ff @(posedge clk) begin
		if (data_re) begin
			data_rd_q <= data_mem[match_idx_q];
		end
		if (data_we) begin
			data_mem[meta_addr] <= value_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			capacity_q    <= CAP_RESET;
			valid_q       <= '0;
			filled_q      <= '0;
			use_clock_q   <= '0;
			scan_idx_q    <= '0;
			chk_s1        <= 1'b0;
			match_found_q <= 1'b0;
			vic_found_q   <= 1'b0;
			free_found_q  <= 1'b0;
			out_valid     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			chk_s1 <= scan_issue;
			if (scan_issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (chk_s1) begin
				if (chk_valid_s1 && !match_found_q && (rd_key_s1 == key_q)) begin
					match_found_q <= 1'b1;
				end
				if (chk_valid_s1 && is_better) begin
					vic_found_q <= 1'b1;
				end
				if (!chk_valid_s1 && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			if (meta_we) begin
				use_clock_q <= use_clock_q + 1'b1;
			end
			valid_q <= valid_d;
			if (do_ins && !do_evict) begin
				filled_q <= filled_q + 1'b1;
			end
			if ((state_q == ST_RESP) && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						scan_idx_q    <= '0;
						match_found_q <= 1'b0;
						vic_found_q   <= 1'b0;
						free_found_q  <= 1'b0;
						state_q       <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// last entry is checked at this edge
					if ((scan_idx_q == LAST_SCAN) && chk_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q <= data_re ? ST_LOAD : ST_RESP;
				end
				ST_LOAD: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q   <= cmd;
			key_q   <= key;
			value_q <= value;
		end
		if (scan_issue) begin
			chk_idx_s1   <= scan_addr;
			chk_valid_s1 <= valid_q[scan_addr];
		end
		if (chk_s1) begin
			if (chk_valid_s1 && !match_found_q && (rd_key_s1 == key_q)) begin
				match_idx_q <= chk_idx_s1;
				match_cnt_q <= rd_cnt_s1;
			end
			if (chk_valid_s1 && is_better) begin
				vic_idx_q   <= chk_idx_s1;
				vic_cnt_q   <= rd_cnt_s1;
				vic_stamp_q <= rd_stamp_s1;
				vic_key_q   <= rd_key_s1;
			end
			if (!chk_valid_s1 && !free_found_q) begin
				free_idx_q <= chk_idx_s1;
			end
		end
		if (state_q == ST_DECIDE) begin
			res_q.hit         <= match_found_q && ((cmd_q == CMD_GET) || (capacity_q != '0));
			res_q.read_value  <= (cmd_q == CMD_GET) ? MISS_VALUE : '0;
			res_q.evicted     <= do_evict;
			res_q.evicted_key <= do_evict ? vic_key_q : '0;
		end
		if (state_q == ST_LOAD) begin
			res_q.read_value <= data_rd_q;
		end
		if ((state_q == ST_RESP) && out_free) begin
			hit         <= res_q.hit;
			read_value  <= res_q.read_value;
			evicted     <= res_q.evicted;
			evicted_key <= res_q.evicted_key;
		end
	end

`ifndef SYNTH
	a_fill_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q == CNT_W'($countones(valid_q)))
		else $error("fill count differs from number of valid entries");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_SCAN) && (scan_idx_q == '0))
		else $error("accepted item did not start a scan");

	a_evict_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) && do_evict |-> !match_found_q && (cmd_q == CMD_PUT))
		else $error("eviction on a hit or a get");

	a_evict_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		do_evict |-> full && (filled_q != '0))
		else $error("eviction while table has room");

	a_resp_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP) && out_free |=> out_valid && (state_q == ST_IDLE))
		else $error("response not presented");
`endif

endmodule
